// File: hdl/assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(name, ck, rn, ante, cons)

`define ASSERT_NEXT(name, ck, rn, ante, cons)

`endif

`endif

// File: hdl/tpti_pkg.sv
package tpti_pkg;

    localparam int MAX_TIERS = 16;
    localparam int CNT_W     = 5;
    localparam int TIER_W    = 4;
    localparam int QUOT_W    = 31;
    localparam int DIV_W     = 66;
    localparam int STEP_W    = $clog2(QUOT_W + 1);
    localparam int ADDR_W    = 5;

    localparam logic [CNT_W-1:0]  MAX_TIERS_C = CNT_W'(MAX_TIERS);
    localparam logic [STEP_W-1:0] QUOT_STEPS  = STEP_W'(QUOT_W);

    localparam logic [2:0] REG_NORMAL_X     = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y     = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z     = 3'd2;
    localparam logic [2:0] REG_PLANE_OFFSET = 3'd3;
    localparam logic [2:0] REG_THICKNESS    = 3'd4;
    localparam logic [2:0] REG_TIER_COUNT   = 3'd5;

    localparam logic [31:0] NORMAL_Z_RST = 32'h4000_0000;

    typedef struct packed {
        logic [31:0]      normal_x;
        logic [31:0]      normal_y;
        logic [31:0]      normal_z;
        logic [31:0]      plane_offset;
        logic [30:0]      layer_thickness;
        logic [CNT_W-1:0] tier_count;
    } cfg_t;

    typedef struct packed {
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] slope_x;
        logic [31:0] slope_y;
    } track_t;

    typedef struct packed {
        logic [31:0]       hit_x;
        logic [31:0]       hit_y;
        logic [31:0]       hit_z;
        logic [TIER_W-1:0] tier_index;
        logic              last;
        logic              saturated;
    } hit_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [DIV_W-1:0]  rem;
    } div_rsp_t;

endpackage

// File: hdl/track_plane_tier_intersection.sv
// Intersects a straight track (offsets at z=0, slopes) with a detector plane
// split into tiers along its normal, and sends one hit per tier that lies in
// front of the track, in tier order, with last set on the final one. A track
// parallel to the plane gives no hits. Work on a track can wait while a hit
// is held by hit_stall. The shared 31-step restoring divider is used once per
// track for the tier spacing and once per emitted tier for the track
// parameter, unless the track parameter saturates; the four dot-product terms
// and the two hit products go through one shared 32x32 multiplier.
// track_stall is high while a track is in work; a finished hit sits in the
// output register, so the next track is taken while it waits.
`include "assert_macros.svh"

module track_plane_tier_intersection (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpti_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          track_valid,
    output logic                          track_stall,
    input  logic signed [31:0]            offset_x,
    input  logic signed [31:0]            offset_y,
    input  logic signed [31:0]            slope_x,
    input  logic signed [31:0]            slope_y,
    output logic                          hit_valid,
    input  logic                          hit_stall,
    output logic signed [31:0]            hit_x,
    output logic signed [31:0]            hit_y,
    output logic signed [31:0]            hit_z,
    output logic [tpti_pkg::TIER_W-1:0]   tier_index,
    output logic                          last,
    output logic                          saturated
);

    logic [31:0]                 normal_x_reg;
    logic [31:0]                 normal_y_reg;
    logic [31:0]                 normal_z_reg;
    logic [31:0]                 plane_offset_reg;
    logic [30:0]                 thickness_reg;
    logic [tpti_pkg::CNT_W-1:0]  tier_count_reg;

    logic                        wr_en;
    logic [2:0]                  reg_idx;
    tpti_pkg::cfg_t              cfg;
    tpti_pkg::track_t            track;
    tpti_pkg::hit_t              hit;
    tpti_pkg::hit_t              hit_data_reg;
    logic                        hit_valid_reg;
    logic                        track_accept;
    logic                        out_free;
    logic                        out_load;
    logic                        busy;
    tpti_pkg::div_req_t          div_req;
    tpti_pkg::div_rsp_t          div_rsp;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg     <= '0;
            normal_y_reg     <= '0;
            normal_z_reg     <= tpti_pkg::NORMAL_Z_RST;
            plane_offset_reg <= '0;
            thickness_reg    <= '0;
            tier_count_reg   <= tpti_pkg::CNT_W'(1);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                tpti_pkg::REG_NORMAL_X:     normal_x_reg     <= pwdata;
                tpti_pkg::REG_NORMAL_Y:     normal_y_reg     <= pwdata;
                tpti_pkg::REG_NORMAL_Z:     normal_z_reg     <= pwdata;
                tpti_pkg::REG_PLANE_OFFSET: plane_offset_reg <= pwdata;
                tpti_pkg::REG_THICKNESS:    thickness_reg    <= pwdata[30:0];
                tpti_pkg::REG_TIER_COUNT:   tier_count_reg   <= pwdata[tpti_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tpti_pkg::REG_NORMAL_X:     prdata = normal_x_reg;
            tpti_pkg::REG_NORMAL_Y:     prdata = normal_y_reg;
            tpti_pkg::REG_NORMAL_Z:     prdata = normal_z_reg;
            tpti_pkg::REG_PLANE_OFFSET: prdata = plane_offset_reg;
            tpti_pkg::REG_THICKNESS:    prdata = {1'b0, thickness_reg};
            tpti_pkg::REG_TIER_COUNT:   prdata = {27'd0, tier_count_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.normal_x        = normal_x_reg;
    assign cfg.normal_y        = normal_y_reg;
    assign cfg.normal_z        = normal_z_reg;
    assign cfg.plane_offset    = plane_offset_reg;
    assign cfg.layer_thickness = thickness_reg;
    assign cfg.tier_count      = tier_count_reg;

    assign track.offset_x = offset_x;
    assign track.offset_y = offset_y;
    assign track.slope_x  = slope_x;
    assign track.slope_y  = slope_y;

    assign track_stall  = busy;
    assign track_accept = track_valid && !track_stall;
    assign out_free     = !hit_valid_reg || !hit_stall;

    tpti_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .track        (track),
        .track_accept (track_accept),
        .out_free     (out_free),
        .busy         (busy),
        .out_load     (out_load),
        .hit          (hit),
        .div_req      (div_req),
        .div_rsp      (div_rsp)
    );

    tpti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output register: holds a hit until its transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_valid_reg <= 1'b0;
        else if (out_load)
            hit_valid_reg <= 1'b1;
        else if (!hit_stall)
            hit_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            hit_data_reg <= hit;
    end

    assign hit_valid  = hit_valid_reg;
    assign hit_x      = hit_data_reg.hit_x;
    assign hit_y      = hit_data_reg.hit_y;
    assign hit_z      = hit_data_reg.hit_z;
    assign tier_index = hit_data_reg.tier_index;
    assign last       = hit_data_reg.last;
    assign saturated  = hit_data_reg.saturated;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, track_accept, track_stall)
    `ASSERT_IMPLY(a_no_hit_overwrite, clk, rst_n, out_load && hit_valid_reg, !hit_stall)
    `ASSERT_IMPLY(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)

endmodule

// File: hdl/tpti_div.sv
// Restoring divider, one quotient bit per cycle. Requires dividend < divisor;
// returns floor(dividend * 2^QUOT_W / divisor) and the final partial remainder.
module tpti_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tpti_pkg::div_req_t req,
    output tpti_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tpti_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [tpti_pkg::DIV_W-1:0]    rem_reg, rem_next;
    logic [tpti_pkg::DIV_W-1:0]    dvsr_reg, dvsr_next;
    logic [tpti_pkg::QUOT_W-1:0]   quot_reg, quot_next;
    logic [tpti_pkg::DIV_W:0]      trial;

    assign trial = {rem_reg, 1'b0} - {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            rem_next  = req.dividend;
            dvsr_next = req.divisor;
            quot_next = '0;
            cnt_next  = tpti_pkg::QUOT_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[tpti_pkg::DIV_W])
            begin
                rem_next  = trial[tpti_pkg::DIV_W-1:0];
                quot_next = {quot_reg[tpti_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[tpti_pkg::DIV_W-2:0], 1'b0};
                quot_next = {quot_reg[tpti_pkg::QUOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tpti_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// File: hdl/tpti_ctrl.sv
// Sequencer with shared 32x32 multiplier; tier spacing and track parameter
// come from the shared divider (the track parameter only when it does not saturate).
module tpti_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  tpti_pkg::cfg_t     cfg,
    input  tpti_pkg::track_t   track,
    input  logic               track_accept,
    input  logic               out_free,
    output logic               busy,
    output logic               out_load,
    output tpti_pkg::hit_t     hit,
    output tpti_pkg::div_req_t div_req,
    input  tpti_pkg::div_rsp_t div_rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MKX  = 4'd1;
    localparam logic [3:0] S_MKY  = 4'd2;
    localparam logic [3:0] S_MBX  = 4'd3;
    localparam logic [3:0] S_MBY  = 4'd4;
    localparam logic [3:0] S_BASE = 4'd5;
    localparam logic [3:0] S_ZDIV = 4'd6;
    localparam logic [3:0] S_NUM  = 4'd7;
    localparam logic [3:0] S_TEST = 4'd8;
    localparam logic [3:0] S_CHK  = 4'd9;
    localparam logic [3:0] S_SDIV = 4'd10;
    localparam logic [3:0] S_MX   = 4'd11;
    localparam logic [3:0] S_MY   = 4'd12;
    localparam logic [3:0] S_HY   = 4'd13;
    localparam logic [3:0] S_ADV  = 4'd14;
    localparam logic [3:0] S_EMIT = 4'd15;

    logic [3:0]                     state_reg, state_next;
    logic                           pend_reg, pend_next;
    logic [31:0]                    bx_reg, bx_next;
    logic [31:0]                    by_reg, by_next;
    logic [31:0]                    kx_reg, kx_next;
    logic [31:0]                    ky_reg, ky_next;
    logic signed [63:0]             prod_reg, prod_next;
    logic signed [63:0]             acc_reg, acc_next;
    logic signed [63:0]             den_reg, den_next;
    logic signed [63:0]             base_reg, base_next;
    logic signed [63:0]             num_reg, num_next;
    logic [62:0]                    anum_reg, anum_next;
    logic [62:0]                    aden_reg, aden_next;
    logic [30:0]                    z_reg, z_next;
    logic [30:0]                    zq_reg, zq_next;
    logic [5:0]                     zr_reg, zr_next;
    logic [5:0]                     zrm_reg, zrm_next;
    logic [tpti_pkg::TIER_W-1:0]    tier_reg, tier_next;
    logic [tpti_pkg::TIER_W-1:0]    hit_tier_reg, hit_tier_next;
    logic [30:0]                    s_reg, s_next;
    logic                           sat_reg, sat_next;
    logic [31:0]                    hx_reg, hx_next;
    logic [31:0]                    hy_reg, hy_next;

    logic signed [31:0]             mul_a, mul_b;
    logic signed [63:0]             prod_q2, prod_q28;
    logic [tpti_pkg::CNT_W-1:0]     n_eff;
    logic [tpti_pkg::TIER_W-1:0]    ntm1;
    logic [5:0]                     two_nt;
    logic [6:0]                     four_nt;
    logic [6:0]                     zsum;
    logic [31:0]                    z_base;
    logic [63:0]                    den_abs, num_abs;
    logic                           skip;
    logic                           cmp_ge;
    logic [32:0]                    hx_sat, hy_sat;

    // {flag, value}: clamp a 37-bit signed sum to 32 bits
    function automatic logic [32:0] sat32(input logic [36:0] v);
        logic [32:0] r;
        begin
            if (v[36:31] == {6{v[36]}})
                r = {1'b0, v[31:0]};
            else if (v[36])
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b1, 32'h7FFF_FFFF};
            return r;
        end
    endfunction

    always_comb
    begin
        n_eff = cfg.tier_count;
        if (cfg.tier_count == '0)
            n_eff = tpti_pkg::CNT_W'(1);
        else if (cfg.tier_count > tpti_pkg::MAX_TIERS_C)
            n_eff = tpti_pkg::MAX_TIERS_C;
    end

    assign ntm1     = tpti_pkg::TIER_W'(n_eff - 1'b1);
    assign two_nt   = {n_eff, 1'b0};
    assign four_nt  = {n_eff, 2'b00};
    assign zsum     = {1'b0, zr_reg} + {zrm_reg, 1'b0};
    assign z_base   = {1'b0, z_reg} + {zq_reg, 1'b0};
    assign prod_q2  = prod_reg >>> 2;
    assign prod_q28 = prod_reg >>> 28;
    assign den_abs  = den_reg[63] ? -den_reg : den_reg;
    assign num_abs  = num_reg[63] ? -num_reg : num_reg;
    assign skip     = (num_reg != '0) && (num_reg[63] != den_reg[63]);
    assign cmp_ge   = {3'b000, anum_reg} >= {aden_reg, 3'b000};
    assign hx_sat   = sat32({{5{bx_reg[31]}}, bx_reg} + prod_q28[36:0]);
    assign hy_sat   = sat32({{5{by_reg[31]}}, by_reg} + prod_q28[36:0]);

    always_comb
    begin
        case (state_reg)
            S_MKY:
            begin
                mul_a = ky_reg;
                mul_b = cfg.normal_y;
            end
            S_MBX:
            begin
                mul_a = bx_reg;
                mul_b = cfg.normal_x;
            end
            S_MBY:
            begin
                mul_a = by_reg;
                mul_b = cfg.normal_y;
            end
            S_MX:
            begin
                mul_a = {1'b0, s_reg};
                mul_b = kx_reg;
            end
            S_MY:
            begin
                mul_a = {1'b0, s_reg};
                mul_b = ky_reg;
            end
            default:
            begin
                mul_a = kx_reg;
                mul_b = cfg.normal_x;
            end
        endcase
    end

    assign div_req.dividend = (state_reg == S_BASE) ? {35'd0, cfg.layer_thickness}
                                                    : {3'b000, anum_reg};
    assign div_req.divisor  = (state_reg == S_BASE) ? {29'd0, two_nt, 31'd0}
                                                    : {aden_reg, 3'b000};

    assign hit.hit_x      = hx_reg;
    assign hit.hit_y      = hy_reg;
    assign hit.hit_z      = {1'b0, s_reg};
    assign hit.tier_index = hit_tier_reg;
    assign hit.last       = (state_reg == S_EMIT) || skip;
    assign hit.saturated  = sat_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        bx_next       = bx_reg;
        by_next       = by_reg;
        kx_next       = kx_reg;
        ky_next       = ky_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        base_next     = base_reg;
        num_next      = num_reg;
        anum_next     = anum_reg;
        aden_next     = aden_reg;
        z_next        = z_reg;
        zq_next       = zq_reg;
        zr_next       = zr_reg;
        zrm_next      = zrm_reg;
        tier_next     = tier_reg;
        hit_tier_next = hit_tier_reg;
        s_next        = s_reg;
        sat_next      = sat_reg;
        hx_next       = hx_reg;
        hy_next       = hy_reg;
        out_load      = 1'b0;
        div_req.start = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                pend_next = 1'b0;
                if (track_accept)
                begin
                    bx_next    = track.offset_x;
                    by_next    = track.offset_y;
                    kx_next    = track.slope_x;
                    ky_next    = track.slope_y;
                    state_next = S_MKX;
                end
            end
            S_MKX:
            begin
                prod_next  = mul_a * mul_b;
                acc_next   = {{6{cfg.normal_z[31]}}, cfg.normal_z, 26'd0};
                state_next = S_MKY;
            end
            S_MKY:
            begin
                prod_next  = mul_a * mul_b;
                acc_next   = acc_reg + prod_q2;
                state_next = S_MBX;
            end
            S_MBX:
            begin
                prod_next  = mul_a * mul_b;
                den_next   = acc_reg + prod_q2;
                acc_next   = {{4{cfg.plane_offset[31]}}, cfg.plane_offset, 28'd0};
                state_next = S_MBY;
            end
            S_MBY:
            begin
                prod_next  = mul_a * mul_b;
                acc_next   = acc_reg - prod_q2;
                aden_next  = den_abs[62:0];
                // parallel track: no hits
                state_next = (den_reg == '0) ? S_IDLE : S_BASE;
            end
            S_BASE:
            begin
                base_next     = acc_reg - prod_q2;
                div_req.start = 1'b1;
                state_next    = S_ZDIV;
            end
            S_ZDIV:
            begin
                if (div_rsp.done)
                begin
                    zq_next    = div_rsp.quot;
                    z_next     = div_rsp.quot;
                    zrm_next   = div_rsp.rem[tpti_pkg::QUOT_W +: 6];
                    zr_next    = div_rsp.rem[tpti_pkg::QUOT_W +: 6];
                    tier_next  = '0;
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                num_next   = base_reg + {5'd0, z_reg, 28'd0};
                state_next = S_TEST;
            end
            S_TEST:
            begin
                // a held hit is last when this tier is skipped
                if (!(pend_reg && !out_free))
                begin
                    out_load  = pend_reg;
                    pend_next = 1'b0;
                    if (skip)
                        state_next = (tier_reg == ntm1) ? S_IDLE : S_ADV;
                    else
                    begin
                        anum_next  = num_abs[62:0];
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                if (cmp_ge)
                begin
                    s_next     = 31'h7FFF_FFFF;
                    sat_next   = 1'b1;
                    state_next = S_MX;
                end
                else
                begin
                    sat_next      = 1'b0;
                    div_req.start = 1'b1;
                    state_next    = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_rsp.done)
                begin
                    s_next     = div_rsp.quot;
                    state_next = S_MX;
                end
            end
            S_MX:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MY;
            end
            S_MY:
            begin
                prod_next  = mul_a * mul_b;
                hx_next    = hx_sat[31:0];
                sat_next   = sat_reg | hx_sat[32];
                state_next = S_HY;
            end
            S_HY:
            begin
                hy_next       = hy_sat[31:0];
                sat_next      = sat_reg | hy_sat[32];
                hit_tier_next = tier_reg;
                if (tier_reg == ntm1)
                    state_next = S_EMIT;
                else
                begin
                    pend_next  = 1'b1;
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                if (zsum >= four_nt)
                begin
                    z_next  = 31'(z_base + 32'd2);
                    zr_next = 6'(zsum - four_nt);
                end
                else if (zsum >= {1'b0, two_nt})
                begin
                    z_next  = 31'(z_base + 32'd1);
                    zr_next = 6'(zsum - {1'b0, two_nt});
                end
                else
                begin
                    z_next  = z_base[30:0];
                    zr_next = zsum[5:0];
                end
                tier_next  = tier_reg + 1'b1;
                state_next = S_NUM;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        kx_reg       <= kx_next;
        ky_reg       <= ky_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        den_reg      <= den_next;
        base_reg     <= base_next;
        num_reg      <= num_next;
        anum_reg     <= anum_next;
        aden_reg     <= aden_next;
        z_reg        <= z_next;
        zq_reg       <= zq_next;
        zr_reg       <= zr_next;
        zrm_reg      <= zrm_next;
        tier_reg     <= tier_next;
        hit_tier_reg <= hit_tier_next;
        s_reg        <= s_next;
        sat_reg      <= sat_next;
        hx_reg       <= hx_next;
        hy_reg       <= hy_next;
    end

endmodule
